/* rtl/core/dq_pkg.sv */
// types, constants and command structs shared by the double-ended queue
// controller, datapath and top level
// no dependencies
package dq_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int KIND_W     = 3;
    localparam int WORD_W     = 32;
    localparam int POS_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int LEN_W      = 7;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int S_TUSER_W  = KIND_W;
    localparam int S_TDATA_W  = ((WORD_W + POS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = STATUS_W;
    localparam int M_TDATA_W  = ((3 * WORD_W + LEN_W + 1 + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_BACK   = 3'd3,
        K_READ_AT    = 3'd4,
        K_INSERT_AT  = 3'd5,
        K_ERASE_AT   = 3'd6,
        K_CLEAR      = 3'd7
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CAPTURE,
        S_INS_RD,
        S_INS_WR,
        S_ERS_RD,
        S_ERS_WR,
        S_FETCH,
        S_FRONT,
        S_BACK,
        S_DONE
    } state_t;

    // write address select
    typedef enum logic [1:0] {
        WS_FRONT_NEW = 2'd0,
        WS_TAIL      = 2'd1,
        WS_POS       = 2'd2,
        WS_IDX       = 2'd3
    } wsel_t;

    // read address select
    typedef enum logic [2:0] {
        RS_FRONT = 3'd0,
        RS_LAST  = 3'd1,
        RS_POS   = 3'd2,
        RS_PREV  = 3'd3,
        RS_NEXT  = 3'd4
    } rsel_t;

    typedef enum logic [1:0] {
        HD_KEEP = 2'd0,
        HD_DEC  = 2'd1,
        HD_INC  = 2'd2,
        HD_ZERO = 2'd3
    } head_op_t;

    typedef enum logic [1:0] {
        CN_KEEP = 2'd0,
        CN_INC  = 2'd1,
        CN_DEC  = 2'd2,
        CN_ZERO = 2'd3
    } cnt_op_t;

    typedef enum logic [1:0] {
        IX_KEEP = 2'd0,
        IX_DEC  = 2'd1,
        IX_INC  = 2'd2
    } idx_op_t;

    typedef struct packed {
        logic     load_op;
        logic     start;
        logic     wr_en;
        wsel_t    wr_sel;
        logic     rd_en;
        rsel_t    rd_sel;
        head_op_t head_op;
        cnt_op_t  cnt_op;
        idx_op_t  idx_op;
        logic     cap_got;
        logic     cap_front;
        logic     cap_back;
        logic     zero_ends;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  ok;
        logic  idx_at_pos;
        logic  erase_done;
        logic  cnt_zero;
        logic  out_busy;
    } stat_t;

endpackage

/* rtl/core/dq_ram.sv */
// generic single-write, single-read memory with registered read data
// no dependencies
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/dq_datapath.sv */
// datapath of the double-ended queue: operand, pointer and result registers
// and the entry store; depends on dq_pkg and dq_ram
module dq_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dq_pkg::cmd_t                   cmd,
    output dq_pkg::stat_t                  stat,
    input  logic [dq_pkg::KIND_W-1:0]      in_kind,
    input  logic [dq_pkg::WORD_W-1:0]      in_value,
    input  logic [dq_pkg::POS_W-1:0]       in_position,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [dq_pkg::STATUS_W-1:0]    out_status,
    output logic [dq_pkg::WORD_W-1:0]      out_read,
    output logic [dq_pkg::WORD_W-1:0]      out_front,
    output logic [dq_pkg::WORD_W-1:0]      out_back,
    output logic [dq_pkg::LEN_W-1:0]       out_length,
    output logic                           out_empty
);

    import dq_pkg::*;

    kind_t                 kind_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [ADDR_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    status_t               st_reg, st_calc;
    logic [WORD_W-1:0]     got_reg, front_reg, back_reg;
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [WORD_W-1:0]     out_read_reg, out_front_reg, out_back_reg;
    logic [LEN_W-1:0]      out_length_reg;
    logic                  out_empty_reg;

    logic [ADDR_W-1:0]     wr_addr, rd_addr, head_m1, head_p1;
    logic [DATA_WIDTH-1:0] wr_data, rd_data;
    logic [CMP_W-1:0]      pos_c, cnt_c;

    function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] hd,
                                               input logic [CNT_W-1:0] lg);
        logic [CNT_W:0] sum;
        begin
            sum = (CNT_W+1)'(hd) + (CNT_W+1)'(lg);
            if (sum >= (CNT_W+1)'(CAPACITY))
            begin
                sum = sum - (CNT_W+1)'(CAPACITY);
            end
            return ADDR_W'(sum);
        end
    endfunction

    assign pos_c   = CMP_W'(pos_reg);
    assign cnt_c   = CMP_W'(count_reg);
    assign head_m1 = (head_reg == '0) ? ADDR_W'(CAPACITY - 1) : head_reg - ADDR_W'(1);
    assign head_p1 = (head_reg == ADDR_W'(CAPACITY - 1)) ? '0 : head_reg + ADDR_W'(1);

    // status of the pending operation
    always_comb
    begin
        st_calc = ST_OK;
        unique case (kind_reg)
            K_PUSH_FRONT, K_PUSH_BACK:
            begin
                if (count_reg == CNT_W'(CAPACITY))
                begin
                    st_calc = ST_FULL;
                end
            end
            K_POP_FRONT, K_POP_BACK:
            begin
                if (count_reg == '0)
                begin
                    st_calc = ST_EMPTY;
                end
            end
            K_READ_AT:
            begin
                priority if (count_reg == '0)
                begin
                    st_calc = ST_EMPTY;
                end
                else if (pos_c >= cnt_c)
                begin
                    st_calc = ST_RANGE;
                end
                else
                begin
                    st_calc = ST_OK;
                end
            end
            K_INSERT_AT:
            begin
                priority if (pos_c > cnt_c)
                begin
                    st_calc = ST_RANGE;
                end
                else if (count_reg == CNT_W'(CAPACITY))
                begin
                    st_calc = ST_FULL;
                end
                else
                begin
                    st_calc = ST_OK;
                end
            end
            K_ERASE_AT:
            begin
                if (pos_c >= cnt_c)
                begin
                    st_calc = ST_RANGE;
                end
            end
            K_CLEAR:
            begin
                st_calc = ST_OK;
            end
            default:
            begin
                st_calc = ST_OK;
            end
        endcase
    end

    // store addressing
    always_comb
    begin
        unique case (cmd.wr_sel)
            WS_FRONT_NEW: wr_addr = head_m1;
            WS_TAIL:      wr_addr = slot(head_reg, count_reg);
            WS_POS:       wr_addr = slot(head_reg, CNT_W'(pos_reg));
            WS_IDX:       wr_addr = slot(head_reg, idx_reg);
            default:      wr_addr = head_reg;
        endcase
        unique case (cmd.rd_sel)
            RS_FRONT: rd_addr = head_reg;
            RS_LAST:  rd_addr = slot(head_reg, count_reg - CNT_W'(1));
            RS_POS:   rd_addr = slot(head_reg, CNT_W'(pos_reg));
            RS_PREV:  rd_addr = slot(head_reg, idx_reg - CNT_W'(1));
            RS_NEXT:  rd_addr = slot(head_reg, idx_reg + CNT_W'(1));
            default:  rd_addr = head_reg;
        endcase
    end

    assign wr_data = (cmd.wr_sel == WS_IDX) ? rd_data : val_reg;

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // pointer, count and shift index
    always_comb
    begin
        unique case (cmd.head_op)
            HD_KEEP: head_next = head_reg;
            HD_DEC:  head_next = head_m1;
            HD_INC:  head_next = head_p1;
            HD_ZERO: head_next = '0;
            default: head_next = head_reg;
        endcase
        unique case (cmd.cnt_op)
            CN_KEEP: count_next = count_reg;
            CN_INC:  count_next = count_reg + CNT_W'(1);
            CN_DEC:  count_next = count_reg - CNT_W'(1);
            CN_ZERO: count_next = '0;
            default: count_next = count_reg;
        endcase
        if (cmd.start)
        begin
            idx_next = (kind_reg == K_INSERT_AT) ? count_reg : CNT_W'(pos_reg);
        end
        else
        begin
            unique case (cmd.idx_op)
                IX_KEEP: idx_next = idx_reg;
                IX_DEC:  idx_next = idx_reg - CNT_W'(1);
                IX_INC:  idx_next = idx_reg + CNT_W'(1);
                default: idx_next = idx_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // operand and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            kind_reg <= kind_t'(in_kind);
            val_reg  <= DATA_WIDTH'(in_value);
            pos_reg  <= in_position;
        end
        if (cmd.start)
        begin
            st_reg  <= st_calc;
            got_reg <= '0;
        end
        if (cmd.cap_got)
        begin
            got_reg <= WORD_W'(rd_data);
        end
        if (cmd.zero_ends)
        begin
            front_reg <= '0;
            back_reg  <= '0;
        end
        if (cmd.cap_front)
        begin
            front_reg <= WORD_W'(rd_data);
        end
        if (cmd.cap_back)
        begin
            back_reg <= WORD_W'(rd_data);
        end
        if (cmd.load_out)
        begin
            out_status_reg <= st_reg;
            out_read_reg   <= got_reg;
            out_front_reg  <= front_reg;
            out_back_reg   <= back_reg;
            out_length_reg <= LEN_W'(count_reg);
            out_empty_reg  <= (count_reg == '0);
        end
    end

    assign stat.kind       = kind_reg;
    assign stat.ok         = (st_calc == ST_OK);
    assign stat.idx_at_pos = (CMP_W'(idx_reg) == pos_c);
    assign stat.erase_done = ((CNT_W+1)'(idx_reg) + (CNT_W+1)'(1)) >= (CNT_W+1)'(count_reg);
    assign stat.cnt_zero   = (count_reg == '0);
    assign stat.out_busy   = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_read   = out_read_reg;
    assign out_front  = out_front_reg;
    assign out_back   = out_back_reg;
    assign out_length = out_length_reg;
    assign out_empty  = out_empty_reg;

endmodule

/* rtl/core/dq_ctrl.sv */
// controller state machine of the double-ended queue: sequences checks,
// shifts and end-value fetches; depends on dq_pkg
module dq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  dq_pkg::stat_t stat,
    output dq_pkg::cmd_t  cmd
);

    import dq_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_op = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.start  = 1'b1;
                state_next = S_FETCH;
                if (stat.ok)
                begin
                    unique case (stat.kind)
                        K_PUSH_FRONT:
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = WS_FRONT_NEW;
                            cmd.head_op = HD_DEC;
                            cmd.cnt_op  = CN_INC;
                        end
                        K_PUSH_BACK:
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WS_TAIL;
                            cmd.cnt_op = CN_INC;
                        end
                        K_POP_FRONT:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RS_FRONT;
                            state_next = S_CAPTURE;
                        end
                        K_POP_BACK:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RS_LAST;
                            state_next = S_CAPTURE;
                        end
                        K_READ_AT:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RS_POS;
                            state_next = S_CAPTURE;
                        end
                        K_INSERT_AT:
                        begin
                            state_next = S_INS_RD;
                        end
                        K_ERASE_AT:
                        begin
                            state_next = S_ERS_RD;
                        end
                        K_CLEAR:
                        begin
                            cmd.head_op = HD_ZERO;
                            cmd.cnt_op  = CN_ZERO;
                        end
                        default:
                        begin
                            state_next = S_FETCH;
                        end
                    endcase
                end
            end
            S_CAPTURE:
            begin
                cmd.cap_got = 1'b1;
                if (stat.kind == K_POP_FRONT)
                begin
                    cmd.head_op = HD_INC;
                    cmd.cnt_op  = CN_DEC;
                end
                else if (stat.kind == K_POP_BACK)
                begin
                    cmd.cnt_op = CN_DEC;
                end
                state_next = S_FETCH;
            end
            S_INS_RD:
            begin
                if (stat.idx_at_pos)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WS_POS;
                    cmd.cnt_op = CN_INC;
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_PREV;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WS_IDX;
                cmd.idx_op = IX_DEC;
                state_next = S_INS_RD;
            end
            S_ERS_RD:
            begin
                if (stat.erase_done)
                begin
                    cmd.cnt_op = CN_DEC;
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_NEXT;
                    state_next = S_ERS_WR;
                end
            end
            S_ERS_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WS_IDX;
                cmd.idx_op = IX_INC;
                state_next = S_ERS_RD;
            end
            S_FETCH:
            begin
                if (stat.cnt_zero)
                begin
                    cmd.zero_ends = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_FRONT;
                    state_next = S_FRONT;
                end
            end
            S_FRONT:
            begin
                cmd.cap_front = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = RS_LAST;
                state_next    = S_BACK;
            end
            S_BACK:
            begin
                cmd.cap_back = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/double_ended_queue.sv */
// double-ended queue top level: stream ports, controller and datapath
// depends on dq_pkg, dq_ctrl, dq_datapath
// every item passes the check, end-value fetch and done states; pops and read_at add a
// capture state, insert_at and erase_at their shift states with a read and a write per
// entry moved; the front and back reads are skipped when the store ends empty
// a new item is taken only in the idle state, after the last one is done; one store read and write per cycle
// the output register holds a result while the next transfer is taken
// reset clears the head pointer, count and handshakes; entries are undefined
module double_ended_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [dq_pkg::S_TDATA_W-1:0] s_axis_tdata,  // value, position
    input  logic [dq_pkg::S_TUSER_W-1:0] s_axis_tuser,  // kind
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // read_value, front_value, back_value, length, is_empty
    output logic [dq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic [dq_pkg::M_TUSER_W-1:0] m_axis_tuser   // status
);

    import dq_pkg::*;

    cmd_t                cmd;
    stat_t               stat;
    logic [STATUS_W-1:0] out_status;
    logic [WORD_W-1:0]   out_read, out_front, out_back;
    logic [LEN_W-1:0]    out_length;
    logic                out_empty;

    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dq_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_kind     (s_axis_tuser[KIND_W-1:0]),
        .in_value    (s_axis_tdata[WORD_W-1:0]),
        .in_position (s_axis_tdata[WORD_W+POS_W-1:WORD_W]),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_status  (out_status),
        .out_read    (out_read),
        .out_front   (out_front),
        .out_back    (out_back),
        .out_length  (out_length),
        .out_empty   (out_empty)
    );

    assign m_axis_tdata = M_TDATA_W'({out_empty, out_length, out_back, out_front, out_read});
    assign m_axis_tuser = out_status;

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_empty == (out_length == '0)))
        else $error("empty flag disagrees with length");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_status == ST_FULL) |-> (out_length == LEN_W'(CAPACITY)))
        else $error("full status with store not full");

    a_empty_st: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_status == ST_EMPTY) |-> out_empty)
        else $error("empty status with entries stored");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("transfer taken while an item is in progress");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// testbench for double_ended_queue: directed and random operation streams with
// random gaps on both stream sides, checked against a scoreboard predictor
// depends on dq_pkg and double_ended_queue
module tb;
    import dq_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1925;
    localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY + 16;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned REPORT_MAX   = 10;

    // share of each operation per burst style, in kind order
    localparam int unsigned OP_WEIGHT [4][8] = '{
        '{30, 30,  4,  4,  8, 20,  3, 1},
        '{ 4,  4, 28, 28,  8,  3, 24, 1},
        '{14, 14, 14, 14, 14, 14, 14, 2},
        '{10, 10,  5,  5, 10, 30, 28, 2}
    };

    typedef struct {
        status_t           status;
        logic [WORD_W-1:0] read_value;
        logic [WORD_W-1:0] front_value;
        logic [WORD_W-1:0] back_value;
        logic [LEN_W-1:0]  length;
        logic              is_empty;
    } dq_result_t;

    class dq_scoreboard;
        logic [WORD_W-1:0] slots [CAPACITY];
        int unsigned       head_slot;
        int unsigned       live_count;
        dq_result_t        expected_results [$];
        int unsigned       error_count;

        function new();
            head_slot   = 0;
            live_count  = 0;
            error_count = 0;
        endfunction

        function int unsigned slot_at(int unsigned idx);
            return (head_slot + idx) % CAPACITY;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void note_transfer(kind_t op, logic [WORD_W-1:0] word,
                                    logic [POS_W-1:0] pos);
            dq_result_t  res;
            int unsigned i;
            res.status     = ST_OK;
            res.read_value = '0;
            case (op)
                K_PUSH_FRONT, K_PUSH_BACK:
                    if (live_count >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else if (op == K_PUSH_FRONT) begin
                        head_slot = (head_slot + CAPACITY - 1) % CAPACITY;
                        slots[head_slot] = word;
                        live_count++;
                    end else begin
                        slots[slot_at(live_count)] = word;
                        live_count++;
                    end
                K_POP_FRONT, K_POP_BACK:
                    if (live_count == 0) begin
                        res.status = ST_EMPTY;
                    end else if (op == K_POP_FRONT) begin
                        res.read_value = slots[head_slot];
                        head_slot = (head_slot + 1) % CAPACITY;
                        live_count--;
                    end else begin
                        res.read_value = slots[slot_at(live_count - 1)];
                        live_count--;
                    end
                K_READ_AT:
                    if (live_count == 0)
                        res.status = ST_EMPTY;
                    else if (pos >= live_count)
                        res.status = ST_RANGE;
                    else
                        res.read_value = slots[slot_at(pos)];
                K_INSERT_AT:
                    if (pos > live_count) begin
                        res.status = ST_RANGE;
                    end else if (live_count >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else begin
                        for (i = live_count; i > pos; i--)
                            slots[slot_at(i)] = slots[slot_at(i - 1)];
                        slots[slot_at(pos)] = word;
                        live_count++;
                    end
                K_ERASE_AT:
                    if (pos >= live_count) begin
                        res.status = ST_RANGE;
                    end else begin
                        for (i = pos; i + 1 < live_count; i++)
                            slots[slot_at(i)] = slots[slot_at(i + 1)];
                        live_count--;
                    end
                default:
                    begin
                        live_count = 0;
                        head_slot  = 0;
                    end
            endcase
            if (live_count == 0) begin
                res.front_value = '0;
                res.back_value  = '0;
            end else begin
                res.front_value = slots[head_slot];
                res.back_value  = slots[slot_at(live_count - 1)];
            end
            res.length   = LEN_W'(live_count);
            res.is_empty = (live_count == 0);
            expected_results.push_back(res);
        endfunction

        function void flag(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            error_count++;
            if (error_count <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
        endfunction

        function void compare(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (got !== want)
                flag(what, want, got);
        endfunction

        function void check_transfer(logic [M_TUSER_W-1:0] st, logic [M_TDATA_W-1:0] d);
            dq_result_t want;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("%0t: result transfer with none pending, status %h data %h",
                             $realtime, st, d);
                return;
            end
            want = expected_results.pop_front();
            compare("status", WORD_W'(want.status), WORD_W'(st));
            compare("read_value", want.read_value, d[WORD_W-1:0]);
            compare("front_value", want.front_value, d[2*WORD_W-1:WORD_W]);
            compare("back_value", want.back_value, d[3*WORD_W-1:2*WORD_W]);
            compare("length", WORD_W'(want.length), WORD_W'(d[3*WORD_W+LEN_W-1:3*WORD_W]));
            compare("is_empty", WORD_W'(want.is_empty), WORD_W'(d[3*WORD_W+LEN_W]));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    dq_scoreboard board;
    int unsigned  calm_left;
    int unsigned  cycle_count;

    double_ended_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // value, position
        .s_axis_tuser  (s_axis_tuser),  // kind
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),  // read_value, front_value, back_value, length, is_empty
        .m_axis_tuser  (m_axis_tuser)   // status
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int unsigned sender_gap();
        int unsigned r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r == 0)
            calm_left = 40;
        if (r < 100)
            return 0;
        if (r < 185)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic drive_item(kind_t op, logic [WORD_W-1:0] word, logic [POS_W-1:0] pos);
        int unsigned gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({pos, word});
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_transfer(op, word, pos);
        @(negedge clk);
    endtask

    function automatic kind_t pick_kind(int unsigned style);
        int unsigned r;
        int unsigned acc;
        r   = $urandom_range(0, 99);
        acc = 0;
        for (int k = 0; k < 8; k++) begin
            acc += OP_WEIGHT[style][k];
            if (r < acc)
                return kind_t'(k);
        end
        return K_CLEAR;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_position(int unsigned len);
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return POS_W'($urandom_range(0, (1 << POS_W) - 1));
        if (r == 1)
            return POS_W'(len);
        if (r == 2)
            return POS_W'(CAPACITY);
        return POS_W'($urandom_range(0, len));
    endfunction

    // result side: ready runs, stall runs and occasional long stretches of no stall
    initial begin : sink
        int unsigned run;
        int unsigned r;
        m_axis_tready = 1'b0;
        @(negedge clk);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                m_axis_tready <= 1'b1;
                run = (r < 4) ? $urandom_range(100, 300) : $urandom_range(1, 12);
            end else begin
                m_axis_tready <= 1'b0;
                run = (r < 94) ? $urandom_range(1, 3) : $urandom_range(10, 50);
            end
            repeat (run) @(negedge clk);
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_transfer(m_axis_tuser, m_axis_tdata);

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL double_ended_queue");
        $finish;
    end

    initial begin : stimulus
        int unsigned style;
        int unsigned burst;
        int unsigned sent;
        kind_t       op;
        board         = new();
        calm_left     = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = K_PUSH_FRONT;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty store and position range corner cases
        drive_item(K_POP_FRONT, '1, '0);
        drive_item(K_POP_BACK, '1, '0);
        drive_item(K_READ_AT, '0, '0);
        drive_item(K_ERASE_AT, '0, '0);
        drive_item(K_INSERT_AT, 32'h0bad_f00d, 7'd1);
        drive_item(K_INSERT_AT, '0, '0);
        drive_item(K_PUSH_BACK, '1, '0);
        drive_item(K_PUSH_FRONT, 32'h1234_5678, '1);
        drive_item(K_INSERT_AT, 32'ha5a5_a5a5, 7'd3);
        drive_item(K_INSERT_AT, 32'h5a5a_5a5a, 7'd1);
        drive_item(K_READ_AT, '0, '0);
        drive_item(K_READ_AT, '0, 7'd4);
        drive_item(K_READ_AT, '0, 7'd5);
        drive_item(K_READ_AT, '0, '1);
        drive_item(K_ERASE_AT, '0, 7'd2);
        drive_item(K_ERASE_AT, '0, 7'd4);
        drive_item(K_INSERT_AT, 32'hdead_beef, 7'd64);
        drive_item(K_POP_FRONT, '0, '0);
        drive_item(K_POP_BACK, '0, '0);
        drive_item(K_CLEAR, '0, '0);
        drive_item(K_READ_AT, '0, '0);
        drive_item(K_PUSH_BACK, 32'h0000_0001, '0);
        drive_item(K_ERASE_AT, '0, '0);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            style = $urandom_range(0, 3);
            burst = $urandom_range(10, 70);
            while (burst > 0 && sent < RANDOM_ITEMS) begin
                if (sent == RANDOM_ITEMS / 2) begin
                    // let the result side catch up completely
                    s_axis_tvalid <= 1'b0;
                    do
                        @(negedge clk);
                    while (board.pending() != 0);
                end
                op = pick_kind(style);
                drive_item(op, pick_word(), pick_position(board.live_count));
                burst--;
                sent++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (board.error_count == 0)
            $display("PASS double_ended_queue");
        else
            $display("FAIL double_ended_queue");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/dq_pkg.sv
rtl/core/dq_ram.sv
rtl/core/dq_datapath.sv
rtl/core/dq_ctrl.sv
rtl/core/double_ended_queue.sv
tb/tb.sv
